// File: hw/rtl/rbp_pkg.sv
// shared types and constants of the replicate border padder
package rbp_pkg;

    localparam int MAX_DIM        = 4096;
    localparam int MAX_RADIUS     = 7;
    localparam int DIM_W          = 13;
    localparam int CNT_W          = 12;
    localparam int RAD_W          = 3;
    localparam int PIX_W          = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [DIM_W-1:0] MIN_DIM_C    = DIM_W'(2);
    localparam logic [DIM_W-1:0] MAX_DIM_C    = DIM_W'(MAX_DIM);
    localparam logic [RAD_W-1:0] MAX_RADIUS_C = RAD_W'(MAX_RADIUS);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [RAD_W-1:0] radius;
    } rbp_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic [PIX_W-1:0] value;
        logic             top;
        logic             bottom;
        logic             left;
        logic             right;
    } rbp_desc_t;

    typedef enum logic [3:0] {
        PH_OWN,
        PH_TOP,
        PH_BOTTOM,
        PH_LEFT,
        PH_RIGHT,
        PH_TL,
        PH_TR,
        PH_BL,
        PH_BR
    } rbp_phase_t;

endpackage

// File: hw/rtl/replicate_border_padder_unit.sv
// top level of the replicate border padder
// Pixels of a width-by-height grayscale image enter in raster order and leave as writes into
// a padded image of (width + 2r) by (height + 2r), with edge pixels copied outward into the
// border and each pixel's final write marked by m_tlast. A pixel is taken every cycle while
// the descriptor queue has room; the write sequencer issues one write per cycle unless
// m_tready stalls the output, so a pixel gives 1 write inside the image, 1 + r on an edge and
// 1 + 2r + r*r on a corner. Any register write restarts the frame and is to be done while no
// pixel is in flight.
module replicate_border_padder_unit #(
    parameter int QUEUE_DEPTH = rbp_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [rbp_pkg::DIM_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // pixel_value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,   // out_x, out_y, out_value, zero fill
    output logic                         m_tlast    // last_copy
);
    import rbp_pkg::*;

    rbp_cfg_t         cfg;
    rbp_desc_t        push_desc, pop_desc;
    logic             q_push, q_pop, q_full, q_empty;
    logic [DIM_W-1:0] out_x, out_y;
    logic [PIX_W-1:0] out_value;

    rbp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (push_desc),
        .cfg       (cfg)
    );

    rbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .pop_desc  (pop_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    rbp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_desc    (pop_desc),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_value (out_value),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = {6'b0, out_value, out_y, out_x};

endmodule

// File: hw/rtl/rbp_front.sv
// front end: configuration registers, raster counters and edge classification
module rbp_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [rbp_pkg::DIM_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rbp_pkg::PIX_W-1:0]    s_tdata,
    input  logic                         q_full,
    output logic                         q_push,
    output rbp_pkg::rbp_desc_t           q_desc,
    output rbp_pkg::rbp_cfg_t            cfg
);
    import rbp_pkg::*;

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [RAD_W-1:0] radius_reg, radius_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic             accept;
    logic             top, bottom, left, right;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && !q_full;

    always_comb begin
        priority if (width_reg < MIN_DIM_C) w_eff = MIN_DIM_C;
        else if (width_reg > MAX_DIM_C)     w_eff = MAX_DIM_C;
        else                                w_eff = width_reg;
        priority if (height_reg < MIN_DIM_C) h_eff = MIN_DIM_C;
        else if (height_reg > MAX_DIM_C)     h_eff = MAX_DIM_C;
        else                                 h_eff = height_reg;
    end

    assign cfg.width  = w_eff;
    assign cfg.height = h_eff;
    assign cfg.radius = (radius_reg > MAX_RADIUS_C) ? MAX_RADIUS_C : radius_reg;

    assign top    = (row_reg == '0);
    assign bottom = (DIM_W'(row_reg) == h_eff - DIM_W'(1));
    assign left   = (col_reg == '0);
    assign right  = (DIM_W'(col_reg) == w_eff - DIM_W'(1));

    assign q_push       = accept;
    assign q_desc.col   = col_reg;
    assign q_desc.row   = row_reg;
    assign q_desc.value = s_tdata;
    assign q_desc.top    = top;
    assign q_desc.bottom = bottom;
    assign q_desc.left   = left;
    assign q_desc.right  = right;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        radius_next = radius_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (accept) begin
            if (right) begin
                col_next = '0;
                row_next = bottom ? '0 : row_reg + CNT_W'(1);
            end else begin
                col_next = col_reg + CNT_W'(1);
            end
        end
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH: begin
                    width_next = cfg_data;
                    col_next   = '0;
                    row_next   = '0;
                end
                REG_HEIGHT: begin
                    height_next = cfg_data;
                    col_next    = '0;
                    row_next    = '0;
                end
                REG_RADIUS: begin
                    radius_next = cfg_data[RAD_W-1:0];
                    col_next    = '0;
                    row_next    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            radius_reg <= RAD_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            radius_reg <= radius_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: hw/rtl/rbp_queue.sv
// small descriptor queue between front end and write sequencer
module rbp_queue #(
    parameter int DEPTH = rbp_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rbp_pkg::rbp_desc_t push_desc,
    input  logic               pop,
    output rbp_pkg::rbp_desc_t pop_desc,
    output logic               full,
    output logic               empty
);
    import rbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

    rbp_desc_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_desc = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W_Q'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W_Q'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/rbp_back.sv
// back end: walks the own and border writes of one pixel into the output register
module rbp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rbp_pkg::rbp_cfg_t           cfg,
    input  logic                        q_empty,
    input  rbp_pkg::rbp_desc_t          q_desc,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rbp_pkg::DIM_W-1:0]   out_x,
    output logic [rbp_pkg::DIM_W-1:0]   out_y,
    output logic [rbp_pkg::PIX_W-1:0]   out_value,
    output logic                        m_tlast
);
    import rbp_pkg::*;

    rbp_phase_t       phase_reg, phase_next;
    logic             active_reg, active_next;
    rbp_desc_t        desc_reg, desc_next;
    logic [RAD_W-1:0] i_reg, i_next;
    logic [RAD_W-1:0] j_reg, j_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [DIM_W-1:0] x_reg, x_next;
    logic [DIM_W-1:0] y_reg, y_next;
    logic [PIX_W-1:0] val_reg, val_next;
    logic             last_reg, last_next;

    logic [8:0]       en;
    logic             has_next;
    rbp_phase_t       nxt;
    logic             rz, i_end, j_end, seg_end, is_last, advance, is_block;
    logic [RAD_W-1:0] rm1;
    logic [DIM_W-1:0] r13, c_r, y_r, w_r, h_r, xi, xj;
    logic [DIM_W-1:0] x_cur, y_cur;

    assign m_tvalid  = m_tvalid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_value = val_reg;
    assign m_tlast   = last_reg;

    assign rz  = (cfg.radius != '0);
    assign rm1 = cfg.radius - RAD_W'(1);
    assign r13 = DIM_W'(cfg.radius);
    assign c_r = DIM_W'(desc_reg.col) + r13;
    assign y_r = DIM_W'(desc_reg.row) + r13;
    assign w_r = cfg.width + r13;
    assign h_r = cfg.height + r13;
    assign xi  = DIM_W'(i_reg);
    assign xj  = DIM_W'(j_reg);

    assign en[0] = 1'b1;
    assign en[1] = rz && desc_reg.top;
    assign en[2] = rz && desc_reg.bottom;
    assign en[3] = rz && desc_reg.left;
    assign en[4] = rz && desc_reg.right;
    assign en[5] = rz && desc_reg.top && desc_reg.left;
    assign en[6] = rz && desc_reg.top && desc_reg.right;
    assign en[7] = rz && desc_reg.bottom && desc_reg.left;
    assign en[8] = rz && desc_reg.bottom && desc_reg.right;

    always_comb begin
        has_next = 1'b0;
        nxt      = PH_OWN;
        for (int k = 8; k >= 1; k--) begin
            if (en[k] && (4'(k) > phase_reg)) begin
                has_next = 1'b1;
                nxt      = rbp_phase_t'(4'(k));
            end
        end
    end

    assign i_end = (i_reg == rm1);
    assign j_end = (j_reg == rm1);

    always_comb begin
        seg_end  = 1'b1;
        is_block = 1'b0;
        x_cur    = c_r;
        y_cur    = y_r;
        unique case (phase_reg)
            PH_OWN: begin
                seg_end = 1'b1;
            end
            PH_TOP: begin
                seg_end = i_end;
                y_cur   = xi;
            end
            PH_BOTTOM: begin
                seg_end = i_end;
                y_cur   = h_r + xi;
            end
            PH_LEFT: begin
                seg_end = i_end;
                x_cur   = xi;
            end
            PH_RIGHT: begin
                seg_end = i_end;
                x_cur   = w_r + xi;
            end
            PH_TL: begin
                seg_end  = i_end && j_end;
                is_block = 1'b1;
                x_cur    = xi;
                y_cur    = xj;
            end
            PH_TR: begin
                seg_end  = i_end && j_end;
                is_block = 1'b1;
                x_cur    = w_r + xi;
                y_cur    = xj;
            end
            PH_BL: begin
                seg_end  = i_end && j_end;
                is_block = 1'b1;
                x_cur    = xi;
                y_cur    = h_r + xj;
            end
            PH_BR: begin
                seg_end  = i_end && j_end;
                is_block = 1'b1;
                x_cur    = w_r + xi;
                y_cur    = h_r + xj;
            end
            default: begin
                seg_end = 1'b1;
            end
        endcase
    end

    assign is_last = seg_end && !has_next;
    assign advance = active_reg && (!m_tvalid_reg || m_tready);

    always_comb begin
        phase_next    = phase_reg;
        active_next   = active_reg;
        desc_next     = desc_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        m_tvalid_next = m_tvalid_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        q_pop         = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (advance) begin
            m_tvalid_next = 1'b1;
            x_next        = x_cur;
            y_next        = y_cur;
            val_next      = desc_reg.value;
            last_next     = is_last;
            if (seg_end) begin
                if (has_next) begin
                    phase_next = nxt;
                    i_next     = '0;
                    j_next     = '0;
                end else begin
                    active_next = 1'b0;
                end
            end else if (is_block && i_end) begin
                i_next = '0;
                j_next = j_reg + RAD_W'(1);
            end else begin
                i_next = i_reg + RAD_W'(1);
            end
        end

        if ((!active_reg || (advance && is_last)) && !q_empty) begin
            q_pop       = 1'b1;
            desc_next   = q_desc;
            phase_next  = PH_OWN;
            i_next      = '0;
            j_next      = '0;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        val_reg  <= val_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_OWN;
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            active_reg   <= active_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
